[hw/rtl/fcrd_pkg.sv]
// shared types and constants of the front-coded rule decoder
package fcrd_pkg;

	localparam int SYM_W = 16;
	localparam int TOT_W = 32;

	// item command codes
	typedef enum logic {
		CMD_HEADER = 1'b0,
		CMD_SYMBOL = 1'b1
	} cmd_code_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_HDR,
		ST_EMIT,
		ST_SYM
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic capture;
		logic hdr_apply;
		logic rd_first;
		logic rd_next;
		logic emit_replay;
		logic emit_sym;
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic plen_zero;
		logic replay_last;
		logic out_free;
	} dp_stat_t;

endpackage

[hw/rtl/fcrd_ctrl.sv]
// controller state machine of the front-coded rule decoder
module fcrd_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_ready,
	input  logic               command,
	input  fcrd_pkg::dp_stat_t stat,
	output fcrd_pkg::dp_cmd_t  cmd
);

	fcrd_pkg::state_t state_q;
	fcrd_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fcrd_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		item_ready = 1'b0;
		cmd        = '0;
		unique case (state_q)
			fcrd_pkg::ST_IDLE: begin
				item_ready = 1'b1;
				if (item_valid) begin
					cmd.capture = 1'b1;
					if (command == fcrd_pkg::CMD_SYMBOL) begin
						state_d = fcrd_pkg::ST_SYM;
					end else begin
						state_d = fcrd_pkg::ST_HDR;
					end
				end
			end
			fcrd_pkg::ST_HDR: begin
				cmd.hdr_apply = 1'b1;
				if (stat.plen_zero) begin
					state_d = fcrd_pkg::ST_IDLE;
				end else begin
					cmd.rd_first = 1'b1;
					state_d      = fcrd_pkg::ST_EMIT;
				end
			end
			fcrd_pkg::ST_EMIT: begin
				if (stat.out_free) begin
					cmd.emit_replay = 1'b1;
					if (stat.replay_last) begin
						state_d = fcrd_pkg::ST_IDLE;
					end else begin
						cmd.rd_next = 1'b1;
					end
				end
			end
			fcrd_pkg::ST_SYM: begin
				if (stat.out_free) begin
					cmd.emit_sym = 1'b1;
					state_d      = fcrd_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = fcrd_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

[hw/rtl/fcrd_dp.sv]
// datapath of the front-coded rule decoder: totals, rule buffer, result register
module fcrd_dp #(
	parameter int MAX_RULE_LEN = 64,
	parameter int SYMBOL_BITS  = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            command,
	input  logic [fcrd_pkg::TOT_W-1:0]      prefix_total,
	input  logic [fcrd_pkg::TOT_W-1:0]      suffix_total,
	input  logic [fcrd_pkg::SYM_W-1:0]      symbol_in,
	input  fcrd_pkg::dp_cmd_t               cmd,
	output fcrd_pkg::dp_stat_t              stat,
	output logic                            result_valid,
	input  logic                            result_ready,
	output logic [fcrd_pkg::SYM_W-1:0]      symbol_out,
	output logic                            rule_first,
	output logic                            last_of_run,
	output logic                            error_flag
);

	localparam int LenW   = $clog2(MAX_RULE_LEN + 1);
	localparam int AddrW  = $clog2(MAX_RULE_LEN);
	localparam int StoreW = (SYMBOL_BITS < fcrd_pkg::SYM_W) ? SYMBOL_BITS : fcrd_pkg::SYM_W;
	localparam logic [LenW-1:0] MaxLen = LenW'(MAX_RULE_LEN);

	// header deltas and captured symbol
	logic [fcrd_pkg::TOT_W-1:0] plen_q;
	logic [fcrd_pkg::TOT_W-1:0] slen_q;
	logic [StoreW-1:0]          sym_q;
	// running totals of the last header
	logic [fcrd_pkg::TOT_W-1:0] last_p_q;
	logic [fcrd_pkg::TOT_W-1:0] last_s_q;
	// rule position state
	logic [LenW-1:0]            wpos_q;
	logic [LenW-1:0]            srem_q;
	logic                       fp_q;
	logic                       err_q;
	logic [LenW-1:0]            rlen_q;
	logic [LenW-1:0]            idx_q;

	logic [StoreW-1:0]          mem [MAX_RULE_LEN];
	logic [StoreW-1:0]          rd_data_q;

	logic                       out_valid_q;
	logic [fcrd_pkg::SYM_W-1:0] out_sym_q;
	logic                       out_first_q;
	logic                       out_last_q;
	logic                       out_err_q;

	logic                       clamp;
	logic [LenW-1:0]            plen_c;
	logic [LenW-1:0]            room;
	logic [LenW-1:0]            slen_c;
	logic [LenW-1:0]            idx_nxt;
	logic [AddrW-1:0]           rd_addr;
	logic                       sym_ok;
	logic                       out_load;

	// clamp prefix to what the previous rule really held, suffix to the room left
	always_comb begin
		clamp   = plen_q > fcrd_pkg::TOT_W'(wpos_q);
		plen_c  = clamp ? wpos_q : plen_q[LenW-1:0];
		room    = MaxLen - plen_c;
		slen_c  = (slen_q > fcrd_pkg::TOT_W'(room)) ? room : slen_q[LenW-1:0];
		idx_nxt = idx_q + LenW'(1);
		rd_addr = cmd.rd_first ? '0 : idx_nxt[AddrW-1:0];
		sym_ok  = (srem_q != '0) && (wpos_q < MaxLen);
		out_load = cmd.emit_replay | cmd.emit_sym;
	end

	assign stat.plen_zero   = (plen_c == '0);
	assign stat.replay_last = (idx_nxt == rlen_q);
	assign stat.out_free    = !out_valid_q || result_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_p_q    <= '0;
			last_s_q    <= '0;
			wpos_q      <= '0;
			srem_q      <= '0;
			fp_q        <= 1'b0;
			err_q       <= 1'b0;
			rlen_q      <= '0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.capture && command == fcrd_pkg::CMD_HEADER) begin
				last_p_q <= prefix_total;
				last_s_q <= suffix_total;
			end
			if (cmd.hdr_apply) begin
				wpos_q <= plen_c;
				srem_q <= slen_c;
				fp_q   <= 1'b1;
				err_q  <= clamp;
				rlen_q <= plen_c;
				idx_q  <= '0;
			end
			if (cmd.emit_replay) begin
				fp_q  <= 1'b0;
				idx_q <= idx_nxt;
			end
			if (cmd.emit_sym && sym_ok) begin
				fp_q   <= 1'b0;
				wpos_q <= wpos_q + LenW'(1);
				srem_q <= srem_q - LenW'(1);
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (result_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// captured item fields
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			plen_q <= prefix_total - last_p_q;
			slen_q <= suffix_total - last_s_q;
			sym_q  <= symbol_in[StoreW-1:0];
		end
	end

	// rule buffer, one write and one registered read
	always_ff @(posedge clk) begin
		if (cmd.emit_sym && sym_ok) begin
			mem[wpos_q[AddrW-1:0]] <= sym_q;
		end
		if (cmd.rd_first || cmd.rd_next) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (cmd.emit_replay) begin
			out_sym_q   <= fcrd_pkg::SYM_W'(rd_data_q);
			out_first_q <= fp_q;
			out_last_q  <= stat.replay_last;
			out_err_q   <= err_q;
		end else if (cmd.emit_sym) begin
			out_sym_q   <= sym_ok ? fcrd_pkg::SYM_W'(sym_q) : '0;
			out_first_q <= sym_ok & fp_q;
			out_last_q  <= 1'b1;
			out_err_q   <= !sym_ok;
		end
	end

	assign result_valid = out_valid_q;
	assign symbol_out   = out_sym_q;
	assign rule_first   = out_first_q;
	assign last_of_run  = out_last_q;
	assign error_flag   = out_err_q;

endmodule

[hw/rtl/front_coded_rule_decoder.sv]
// top level of the front-coded rule decoder
//
// channel   signals                                         direction
// item      item_valid/item_ready, command, prefix_total,   into block
//           suffix_total, symbol_in
// result    result_valid/result_ready, symbol_out,          out of block
//           rule_first, last_of_run, error_flag
//
// one request at a time: a symbol request emits one result; a header replays its
// prefix symbols one by one through the single read port of the rule buffer
// a header with an empty prefix gives no result and returns to idle from ST_HDR
// arst_n clears totals, positions and flags; the rule buffer is not cleared
// a stalled result holds the controller in ST_EMIT or ST_SYM, which take no new request
module front_coded_rule_decoder #(
	parameter int MAX_RULE_LEN = 64,
	parameter int SYMBOL_BITS  = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	// item channel
	input  logic                       item_valid,
	output logic                       item_ready,
	input  logic                       command,
	input  logic [fcrd_pkg::TOT_W-1:0] prefix_total,
	input  logic [fcrd_pkg::TOT_W-1:0] suffix_total,
	input  logic [fcrd_pkg::SYM_W-1:0] symbol_in,
	// result channel
	output logic                       result_valid,
	input  logic                       result_ready,
	output logic [fcrd_pkg::SYM_W-1:0] symbol_out,
	output logic                       rule_first,
	output logic                       last_of_run,
	output logic                       error_flag
);

	fcrd_pkg::dp_cmd_t  dp_cmd;
	fcrd_pkg::dp_stat_t dp_stat;

	// sequencing: capture, header clamp, prefix replay, suffix symbol
	fcrd_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.command    (command),
		.stat       (dp_stat),
		.cmd        (dp_cmd)
	);

	// total deltas, rule buffer and the result register
	fcrd_dp #(
		.MAX_RULE_LEN (MAX_RULE_LEN),
		.SYMBOL_BITS  (SYMBOL_BITS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.command      (command),
		.prefix_total (prefix_total),
		.suffix_total (suffix_total),
		.symbol_in    (symbol_in),
		.cmd          (dp_cmd),
		.stat         (dp_stat),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.symbol_out   (symbol_out),
		.rule_first   (rule_first),
		.last_of_run  (last_of_run),
		.error_flag   (error_flag)
	);

endmodule

[hw/rtl/fcrd_checker.sv]
// port-level checks of the front-coded rule decoder and their binding
module fcrd_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       item_valid,
	input logic                       item_ready,
	input logic                       result_valid,
	input logic                       result_ready,
	input logic [fcrd_pkg::SYM_W-1:0] symbol_out,
	input logic                       rule_first,
	input logic                       last_of_run,
	input logic                       error_flag
);

	// a stalled result holds
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(symbol_out) &&
			$stable(rule_first) && $stable(last_of_run) && $stable(error_flag))
		else $error("result changed while stalled");

	// one request in work at a time
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready |=> !item_ready)
		else $error("request taken right after another");

	// no new request while a replay run is still open
	a_run_busy: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !last_of_run |-> !item_ready)
		else $error("request taken during a replay run");

	// a replay run continues without a gap
	a_run_next: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_ready && !last_of_run |=> result_valid)
		else $error("replay run broke off");

endmodule

bind front_coded_rule_decoder fcrd_checker u_fcrd_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_valid   (item_valid),
	.item_ready   (item_ready),
	.result_valid (result_valid),
	.result_ready (result_ready),
	.symbol_out   (symbol_out),
	.rule_first   (rule_first),
	.last_of_run  (last_of_run),
	.error_flag   (error_flag)
);
